>>> rtl/rpwcd_pkg.sv
package rpwcd_pkg;

  // field widths
  localparam int PULSE_W   = 16;
  localparam int CODE_W    = 24;
  localparam int CFG_W     = 16;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  // default frame length in pulses
  localparam int FRAME_PULSES_DEF = 25;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_PULSE_RST = 16'd150;
  localparam logic [CFG_W-1:0] MAX_PULSE_RST = 16'd1800;
  localparam logic [CFG_W-1:0] SYNC_GAP_RST  = 16'd5000;
  localparam logic [CFG_W-1:0] BIT_BOUND_RST = 16'd800;
  localparam logic [CFG_W-1:0] HOLD_RST      = 16'd500;

  // register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_GAP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BIT_BOUND = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HOLD      = 3'd4;

  // window scaling: x/10 == (x * RECIP_TENTH) >> RECIP_SHIFT, exact for x < 2^22
  localparam int SCL_W       = 20;
  localparam int WIN_W       = 17;
  localparam int RECIP_SHIFT = 23;
  localparam logic [SCL_W-1:0] RECIP_TENTH = 20'd838861;

  // number of window values (lo0, hi0, lo1, hi1)
  localparam int NUM_WIN = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_CHK,
    ST_DIV,
    ST_SCALE,
    ST_PASS2,
    ST_FIN,
    ST_WAIT
  } st_t;

  typedef struct packed {
    logic              code_valid;
    logic [CODE_W-1:0] code;
    logic              led_on;
  } res_t;

endpackage

>>> rtl/rpwcd_ram.sv
module rpwcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rpwcd_div.sv
module rpwcd_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    trial;
  logic              ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem_r, q_r[NUM_W-1]};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      q_nxt    = {q_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

>>> rtl/rf_pulse_width_code_decoder.sv
// Tick, falling edge and short or non-frame rising edge write their result into the output
//   register, or park it in ST_WAIT (input stalled) while that register is full.
// A frame check is paced by two sweeps through the single read port of the pulse memory
//   and by the bit-serial divider.
// One item at a time; a result waiting in the output register does not block the next item.
// Reset (synchronous, rst_n low): registers to defaults, count, code, timer and LED cleared.
module rf_pulse_width_code_decoder #(
  parameter int FRAME_PULSES = rpwcd_pkg::FRAME_PULSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic                           in_edge_level,
  input  logic [rpwcd_pkg::PULSE_W-1:0]  in_pulse_duration,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_code_valid,
  output logic [rpwcd_pkg::CODE_W-1:0]   out_code,
  output logic                           out_led_on,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpwcd_pkg::APB_AW-1:0]   paddr,
  input  logic [rpwcd_pkg::APB_DW-1:0]   pwdata,
  output logic [rpwcd_pkg::APB_DW-1:0]   prdata,
  output logic                           pready
);

  import rpwcd_pkg::*;

  localparam int CNT_W = $clog2(FRAME_PULSES + 1);
  localparam int SUM_W = PULSE_W + CNT_W;
  localparam int ACC_W = CODE_W + 1;
  localparam int PROD_W = 2 * SCL_W;
  localparam int DEPTH = FRAME_PULSES + 1;
  localparam logic [CNT_W-1:0] FP_C = CNT_W'(FRAME_PULSES);

  // configuration registers
  logic [CFG_W-1:0] min_r, max_r, sync_r, bnd_r, hold_cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  // control state
  st_t               state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic [CFG_W-1:0]  hold_r, hold_nxt;
  logic              ind_r, ind_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              rv_r, rv_nxt;
  logic [2:0]        scl_r, scl_nxt;
  logic              out_valid_r, out_valid_nxt;

  // frame check datapath
  logic [SUM_W-1:0]  sum0_r, sum0_nxt, sum1_r, sum1_nxt;
  logic [CNT_W-1:0]  n0_r, n0_nxt, n1_r, n1_nxt;
  logic [WIN_W-1:0]  win_r [NUM_WIN];
  logic [WIN_W-1:0]  win_nxt [NUM_WIN];
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              bad_r, bad_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r, out_nxt;

  // memory and divider hookup
  logic               ram_we, ram_re;
  logic [CNT_W-1:0]   ram_raddr;
  logic [PULSE_W-1:0] ram_rdata;
  logic               div_start, div0_done, div1_done;
  logic [SUM_W-1:0]   div0_q, div1_q;

  // misc combinational
  logic               in_accept, out_free, fin_go;
  res_t               fin_res;
  logic [SCL_W-1:0]   scale_x;
  logic [PULSE_W-1:0] a0, a1;
  logic [WIN_W-1:0]   p_ext;
  logic [CODE_W-1:0]  cand;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= MIN_PULSE_RST;
      max_r      <= MAX_PULSE_RST;
      sync_r     <= SYNC_GAP_RST;
      bnd_r      <= BIT_BOUND_RST;
      hold_cfg_r <= HOLD_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_PULSE: min_r      <= pwdata[CFG_W-1:0];
        REG_MAX_PULSE: max_r      <= pwdata[CFG_W-1:0];
        REG_SYNC_GAP:  sync_r     <= pwdata[CFG_W-1:0];
        REG_BIT_BOUND: bnd_r      <= pwdata[CFG_W-1:0];
        REG_HOLD:      hold_cfg_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_PULSE: prdata = APB_DW'(min_r);
      REG_MAX_PULSE: prdata = APB_DW'(max_r);
      REG_SYNC_GAP:  prdata = APB_DW'(sync_r);
      REG_BIT_BOUND: prdata = APB_DW'(bnd_r);
      REG_HOLD:      prdata = APB_DW'(hold_cfg_r);
      default:       prdata = '0;
    endcase
  end

  // pulse memory
  rpwcd_ram #(
    .WIDTH (PULSE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r),
    .wdata (in_pulse_duration),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // class averages, both lanes run side by side
  rpwcd_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum0_r),
    .den   (n0_r),
    .done  (div0_done),
    .quot  (div0_q)
  );

  rpwcd_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum1_r),
    .den   (n1_r),
    .done  (div1_done),
    .quot  (div1_q)
  );

  // handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // scaler operand: avg*6 or avg*16 for either class
  assign a0 = div0_q[PULSE_W-1:0];
  assign a1 = div1_q[PULSE_W-1:0];

  always_comb begin
    unique case (scl_r[1:0])
      2'd0: scale_x = (SCL_W'(a0) << 2) + (SCL_W'(a0) << 1);
      2'd1: scale_x = {a0, 4'b0000};
      2'd2: scale_x = (SCL_W'(a1) << 2) + (SCL_W'(a1) << 1);
      2'd3: scale_x = {a1, 4'b0000};
    endcase
  end

  assign p_ext = {1'b0, ram_rdata};
  assign cand  = acc_r[CODE_W:1];

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    hold_nxt      = hold_r;
    ind_nxt       = ind_r;
    iss_nxt       = iss_r;
    rv_nxt        = 1'b0;
    scl_nxt       = scl_r;
    sum0_nxt      = sum0_r;
    sum1_nxt      = sum1_r;
    n0_nxt        = n0_r;
    n1_nxt        = n1_r;
    win_nxt       = win_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = iss_r;
    div_start     = 1'b0;
    fin_go        = 1'b0;
    fin_res       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (in_func) begin
            // millisecond tick: run down the hold timer
            if (ind_r) begin
              if (hold_r <= CFG_W'(1)) begin
                hold_nxt = '0;
                ind_nxt  = 1'b0;
                prev_nxt = '0;
              end else begin
                hold_nxt = hold_r - CFG_W'(1);
              end
            end
            fin_go = 1'b1;
          end else if (!in_edge_level) begin
            // falling edge: store pulse or drop the frame
            if (in_pulse_duration > min_r && in_pulse_duration < max_r) begin
              ram_we  = 1'b1;
              cnt_nxt = (cnt_r == FP_C) ? '0 : cnt_r + CNT_W'(1);
            end else begin
              cnt_nxt = '0;
            end
            fin_go = 1'b1;
          end else if (in_pulse_duration > sync_r) begin
            // end of frame
            cnt_nxt = '0;
            if (cnt_r == FP_C) begin
              state_nxt = ST_PASS1;
              iss_nxt   = '0;
              sum0_nxt  = '0;
              sum1_nxt  = '0;
              n0_nxt    = '0;
              n1_nxt    = '0;
            end else begin
              fin_go = 1'b1;
            end
          end else begin
            fin_go = 1'b1;
          end
        end
      end

      ST_PASS1: begin
        // sweep the store and sum each class
        if (iss_r < FP_C) begin
          ram_re  = 1'b1;
          iss_nxt = iss_r + CNT_W'(1);
          rv_nxt  = 1'b1;
        end
        if (rv_r) begin
          if (ram_rdata < bnd_r) begin
            sum0_nxt = sum0_r + SUM_W'(ram_rdata);
            n0_nxt   = n0_r + CNT_W'(1);
          end else begin
            sum1_nxt = sum1_r + SUM_W'(ram_rdata);
            n1_nxt   = n1_r + CNT_W'(1);
          end
        end
        if (iss_r == FP_C) begin
          state_nxt = ST_CHK;
        end
      end

      ST_CHK: begin
        // an empty class rejects the frame
        if (n0_r == '0 || n1_r == '0) begin
          fin_go = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div0_done && div1_done) begin
          scl_nxt   = '0;
          state_nxt = ST_SCALE;
        end
      end

      ST_SCALE: begin
        // one multiply per cycle; each product is registered in prod_r, then copied into its window
        if (scl_r < 3'd4) begin
          prod_nxt = scale_x * RECIP_TENTH;
        end
        if (scl_r != 3'd0) begin
          win_nxt[2'(scl_r - 3'd1)] = prod_r[RECIP_SHIFT +: WIN_W];
        end
        scl_nxt = scl_r + 3'd1;
        if (scl_r == 3'd4) begin
          state_nxt = ST_PASS2;
          iss_nxt   = '0;
          acc_nxt   = '0;
          bad_nxt   = 1'b0;
        end
      end

      ST_PASS2: begin
        // second sweep: classify each pulse into a bit
        if (iss_r < FP_C) begin
          ram_re  = 1'b1;
          iss_nxt = iss_r + CNT_W'(1);
          rv_nxt  = 1'b1;
        end
        if (rv_r) begin
          priority if (p_ext > win_r[0] && p_ext < win_r[1]) begin
            acc_nxt = {acc_r[ACC_W-2:0], 1'b0};
          end else if (p_ext > win_r[2] && p_ext < win_r[3]) begin
            acc_nxt = {acc_r[ACC_W-2:0], 1'b1};
          end else begin
            bad_nxt = 1'b1;
          end
        end
        if (iss_r == FP_C) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // accepted frame: refresh LED and timer, report a new code
        if (!bad_r) begin
          ind_nxt  = 1'b1;
          hold_nxt = hold_cfg_r;
          if (cand != '0 && cand != prev_r) begin
            fin_res.code_valid = 1'b1;
            fin_res.code       = cand;
            prev_nxt           = cand;
          end
        end
        fin_go = 1'b1;
      end

      ST_WAIT: begin
        // result parked until the output register frees up
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // hand the finished result to the output register or park it
    fin_res.led_on = ind_nxt;
    if (fin_go) begin
      if (out_free) begin
        out_nxt       = fin_res;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = ST_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      prev_r      <= '0;
      hold_r      <= '0;
      ind_r       <= 1'b0;
      iss_r       <= '0;
      rv_r        <= 1'b0;
      scl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      hold_r      <= hold_nxt;
      ind_r       <= ind_nxt;
      iss_r       <= iss_nxt;
      rv_r        <= rv_nxt;
      scl_r       <= scl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sum0_r  <= sum0_nxt;
    sum1_r  <= sum1_nxt;
    n0_r    <= n0_nxt;
    n1_r    <= n1_nxt;
    win_r   <= win_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    bad_r   <= bad_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // result port
  assign out_valid      = out_valid_r;
  assign out_code_valid = out_r.code_valid;
  assign out_code       = out_r.code;
  assign out_led_on     = out_r.led_on;

`ifndef SYNTH
  // LED off means the timer and the remembered code are both clear
  a_off_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ind_r |-> (hold_r == '0 && prev_r == '0))
    else $error("hold timer or previous code set while LED off");

  // both divider lanes finish in the same cycle
  a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
    div0_done == div1_done)
    else $error("divider lanes out of step");

  // an accepted item is either in the output register or still being worked on
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (out_valid_r || state_r != ST_IDLE))
    else $error("accepted item lost");

  // pulse count never passes the frame length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cnt_r <= FP_C) |-> (cnt_r <= FP_C))
    else $error("pulse count out of range");
`endif

endmodule

>>> tb/code_decode_checker.sv
`timescale 1ns / 1ps

module code_decode_checker #(
  parameter int FRAME_PULSES = rpwcd_pkg::FRAME_PULSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_func,
  input  logic                          in_edge_level,
  input  logic [rpwcd_pkg::PULSE_W-1:0] in_pulse_duration,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_code_valid,
  input  logic [rpwcd_pkg::CODE_W-1:0]  out_code,
  input  logic                          out_led_on,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [rpwcd_pkg::APB_AW-1:0]  paddr,
  input  logic [rpwcd_pkg::APB_DW-1:0]  pwdata,
  output int                            errors,
  output int                            pending,
  output int                            n_results,
  output int                            n_reported,
  output int                            n_decoded,
  output int                            n_timeouts
);

  localparam int PRINT_CAP = 100;

  // shadow of the register file
  logic [rpwcd_pkg::CFG_W-1:0] min_us, max_us, sync_us, bound_us, hold_cfg;

  // shadow of the decoder state
  logic [rpwcd_pkg::PULSE_W-1:0] pulse_mem [0:FRAME_PULSES];
  int unsigned                   pulse_cnt;
  logic [rpwcd_pkg::CODE_W-1:0]  last_code;
  logic [rpwcd_pkg::CFG_W-1:0]   hold_cnt;
  logic                          led;

  rpwcd_pkg::res_t predicted_reports[$];
  rpwcd_pkg::res_t want;

  task automatic report(string what, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: mismatch on %s, predicted %0h, got %0h", $time, what, want_v, got_v);
  endtask

  // class averages, windows and bit slicing of one stored frame
  function automatic logic frame_code(output logic [rpwcd_pkg::CODE_W-1:0] c);
    int unsigned sum0, sum1, n0, n1, a0, a1, lo0, hi0, lo1, hi1, p;
    logic [63:0] acc;
    sum0 = 0;
    sum1 = 0;
    n0 = 0;
    n1 = 0;
    acc = '0;
    c = '0;
    for (int i = 0; i < FRAME_PULSES; i++) begin
      p = 32'(pulse_mem[i]);
      if (p < bound_us) begin
        sum0 += p;
        n0++;
      end else begin
        sum1 += p;
        n1++;
      end
    end
    if (n0 == 0 || n1 == 0) return 1'b0;
    a0 = sum0 / n0;
    a1 = sum1 / n1;
    lo0 = a0 * 32'd6 / 32'd10;
    hi0 = a0 * 32'd16 / 32'd10;
    lo1 = a1 * 32'd6 / 32'd10;
    hi1 = a1 * 32'd16 / 32'd10;
    for (int i = 0; i < FRAME_PULSES; i++) begin
      p = 32'(pulse_mem[i]);
      if (p > lo0 && p < hi0) acc = acc << 1;
      else if (p > lo1 && p < hi1) acc = (acc << 1) | 64'd1;
      else return 1'b0;
    end
    c = acc[rpwcd_pkg::CODE_W:1];
    return 1'b1;
  endfunction

  // one item through the decoder: tick, falling edge or rising edge
  function automatic rpwcd_pkg::res_t decode_item(logic f, logic lvl,
                                                  logic [rpwcd_pkg::PULSE_W-1:0] dur);
    rpwcd_pkg::res_t r;
    logic [rpwcd_pkg::CODE_W-1:0] c;
    r = '0;
    if (f) begin
      if (led) begin
        if (hold_cnt <= 1) begin
          hold_cnt = '0;
          led = 1'b0;
          last_code = '0;
          n_timeouts++;
        end else begin
          hold_cnt--;
        end
      end
    end else if (!lvl) begin
      if (dur > min_us && dur < max_us) begin
        if (pulse_cnt <= FRAME_PULSES) pulse_mem[pulse_cnt] = dur;
        pulse_cnt++;
        if (pulse_cnt > FRAME_PULSES) pulse_cnt = 0;
      end else begin
        pulse_cnt = 0;
      end
    end else if (dur > sync_us) begin
      if (pulse_cnt == FRAME_PULSES && frame_code(c)) begin
        led = 1'b1;
        hold_cnt = hold_cfg;
        n_decoded++;
        if (c != '0 && c != last_code) begin
          r.code_valid = 1'b1;
          r.code = c;
          last_code = c;
          n_reported++;
        end
      end
      pulse_cnt = 0;
    end
    r.led_on = led;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      min_us = rpwcd_pkg::MIN_PULSE_RST;
      max_us = rpwcd_pkg::MAX_PULSE_RST;
      sync_us = rpwcd_pkg::SYNC_GAP_RST;
      bound_us = rpwcd_pkg::BIT_BOUND_RST;
      hold_cfg = rpwcd_pkg::HOLD_RST;
      pulse_cnt = 0;
      last_code = '0;
      hold_cnt = '0;
      led = 1'b0;
      predicted_reports.delete();
      errors = 0;
      n_results = 0;
      n_reported = 0;
      n_decoded = 0;
      n_timeouts = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[rpwcd_pkg::APB_AW-1:2])
          rpwcd_pkg::REG_MIN_PULSE: min_us = pwdata[rpwcd_pkg::CFG_W-1:0];
          rpwcd_pkg::REG_MAX_PULSE: max_us = pwdata[rpwcd_pkg::CFG_W-1:0];
          rpwcd_pkg::REG_SYNC_GAP:  sync_us = pwdata[rpwcd_pkg::CFG_W-1:0];
          rpwcd_pkg::REG_BIT_BOUND: bound_us = pwdata[rpwcd_pkg::CFG_W-1:0];
          rpwcd_pkg::REG_HOLD:      hold_cfg = pwdata[rpwcd_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
      // compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        n_results++;
        if (predicted_reports.size() == 0) begin
          report("result with no item pending", 32'd0, 32'(out_code));
        end else begin
          want = predicted_reports.pop_front();
          if (out_code_valid !== want.code_valid)
            report("code_valid", 32'(want.code_valid), 32'(out_code_valid));
          if (out_code !== want.code) report("code", 32'(want.code), 32'(out_code));
          if (out_led_on !== want.led_on)
            report("led_on", 32'(want.led_on), 32'(out_led_on));
        end
      end
      // predict an accepted item
      if (in_valid && !in_stall)
        predicted_reports.push_back(decode_item(in_func, in_edge_level, in_pulse_duration));
    end
    pending = predicted_reports.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  import rpwcd_pkg::*;

  localparam int FRAME          = FRAME_PULSES_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int NUM_SETTINGS   = 6;

  // one register setting and the pulse ranges that suit it
  typedef struct packed {
    logic [15:0] min_p, max_p, sync, bound, hold;
    logic [15:0] s_lo, s_hi, l_lo, l_hi, outlier, budget;
  } phase_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_func = 1'b0;
  logic              in_edge_level = 1'b0;
  logic [PULSE_W-1:0] in_pulse_duration = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_code_valid;
  logic [CODE_W-1:0] out_code;
  logic              out_led_on;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int errors, pending, n_results, n_reported, n_decoded, n_timeouts;
  int n_items = 0;
  int n_settings = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int quiet = 0;

  phase_t      cur;
  logic [15:0] train[$];
  logic [15:0] last_frame[$];

  rf_pulse_width_code_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_edge_level     (in_edge_level),
    .in_pulse_duration (in_pulse_duration),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_valid    (out_code_valid),
    .out_code          (out_code),
    .out_led_on        (out_led_on),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  code_decode_checker #(.FRAME_PULSES(FRAME)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_edge_level     (in_edge_level),
    .in_pulse_duration (in_pulse_duration),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_valid    (out_code_valid),
    .out_code          (out_code),
    .out_led_on        (out_led_on),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .errors            (errors),
    .pending           (pending),
    .n_results         (n_results),
    .n_reported        (n_reported),
    .n_decoded         (n_decoded),
    .n_timeouts        (n_timeouts)
  );

  always #4 clk = ~clk;

  // random back-pressure on results
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic phase_t plan_of(int k);
    case (k)
      // min, max, sync, bound, hold, short range, long range, outlier, items
      0: return '{16'd150, 16'd1800, 16'd5000, 16'd800, 16'd40,
                  16'd250, 16'd500, 16'd900, 16'd1500, 16'd151, 16'd70};
      1: return '{16'd0, 16'd65535, 16'd0, 16'd800, 16'd1,
                  16'd200, 16'd400, 16'd1500, 16'd2500, 16'd1, 16'd70};
      2: return '{16'd2000, 16'd20000, 16'd30000, 16'd6000, 16'd0,
                  16'd2500, 16'd4000, 16'd8000, 16'd15000, 16'd5800, 16'd70};
      3: return '{16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd65535,
                  16'd250, 16'd500, 16'd900, 16'd1500, 16'd151, 16'd30};
      4: return '{16'd100, 16'd3000, 16'd4000, 16'd0, 16'd2,
                  16'd250, 16'd500, 16'd900, 16'd1500, 16'd101, 16'd30};
      default: return '{MIN_PULSE_RST, MAX_PULSE_RST, SYNC_GAP_RST, BIT_BOUND_RST, HOLD_RST,
                        16'd250, 16'd500, 16'd900, 16'd1500, 16'd700, 16'd60};
    endcase
  endfunction

  // one item, with random idle cycles in front of it
  task automatic send_item(logic f, logic lvl, logic [15:0] dur);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_edge_level <= lvl;
    in_pulse_duration <= dur;
    do @(posedge clk); while (in_stall !== 1'b0);
    n_items++;
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drop valid, drain all results, then let a frame check finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pulse(logic long_p);
    return long_p ? 16'($urandom_range(cur.l_hi, cur.l_lo))
                  : 16'($urandom_range(cur.s_hi, cur.s_lo));
  endfunction

  task automatic fill_frame(int n);
    repeat (n) train.push_back(rand_pulse(1'($urandom_range(1))));
  endtask

  // rising edge after a gap long enough to end the frame
  task automatic sync_edge();
    if (cur.sync == 16'hFFFF) send_item(1'b0, 1'b1, 16'hFFFF);
    else if ($urandom_range(1)) send_item(1'b0, 1'b1, cur.sync + 16'd1);
    else send_item(1'b0, 1'b1, 16'($urandom_range(65535, cur.sync + 1)));
  endtask

  // pulses of the train as falling edges, with short gaps and ticks between
  task automatic send_train();
    int r;
    foreach (train[i]) begin
      send_item(1'b0, 1'b0, train[i]);
      r = $urandom_range(99);
      if (r < 25)
        send_item(1'b0, 1'b1, $urandom_range(3) == 0 ? cur.sync : 16'($urandom_range(cur.sync)));
      else if (r < 35)
        send_item(1'b1, 1'($urandom_range(1)), 16'($urandom_range(65535)));
    end
    sync_edge();
  endtask

  task automatic run_phase();
    int start;
    int kind;
    int ticks;
    logic lb;
    start = n_items;
    while (n_items - start < cur.budget) begin
      kind = $urandom_range(99);
      train.delete();
      if (kind < 93) begin
        if (kind < 60) begin
          fill_frame(FRAME);
        end else if (kind < 65) begin
          // same frame again: repeat suppression
          if (last_frame.size() == 0) fill_frame(FRAME);
          else train = last_frame;
        end else if (kind < 70) begin
          // all leading bits zero
          repeat (FRAME - 1) train.push_back(rand_pulse(1'b0));
          train.push_back(rand_pulse(1'b1));
        end else if (kind < 74) begin
          // one class left empty
          lb = 1'($urandom_range(1));
          repeat (FRAME) train.push_back(rand_pulse(lb));
        end else if (kind < 79) begin
          // one pulse outside both windows
          fill_frame(FRAME);
          train[$urandom_range(FRAME - 1)] = cur.outlier;
        end else if (kind < 83) begin
          fill_frame(FRAME - 1);
        end else if (kind < 86) begin
          fill_frame(FRAME + 1);
        end else if (kind < 88) begin
          // count wraps, then a full frame follows
          fill_frame(2 * FRAME + 1);
        end else begin
          // a pulse on a bound clears the count
          fill_frame(FRAME);
          train[$urandom_range(FRAME - 1)] = $urandom_range(1) ? cur.min_p : cur.max_p;
        end
        send_train();
        if (kind < 60) last_frame = train;
      end else if (kind < 97) begin
        // ticks to run out the hold timer
        ticks = (cur.hold + 2 > 60) ? 60 : cur.hold + 2;
        repeat (ticks) send_item(1'b1, 1'($urandom_range(1)), 16'($urandom_range(65535)));
      end else begin
        repeat (20) send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                              16'($urandom_range(65535)));
        sync_edge();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single items at reset settings: bounds and extremes
    snd_idle_pct = 6;
    rcv_stall_pct = 84;
    send_item(1'b1, 1'b1, 16'hFFFF);
    send_item(1'b1, 1'b0, 16'h0000);
    send_item(1'b0, 1'b0, 16'h0000);
    send_item(1'b0, 1'b0, 16'hFFFF);
    send_item(1'b0, 1'b0, MIN_PULSE_RST);
    send_item(1'b0, 1'b0, MIN_PULSE_RST + 16'd1);
    send_item(1'b0, 1'b0, MAX_PULSE_RST - 16'd1);
    send_item(1'b0, 1'b0, MAX_PULSE_RST);
    send_item(1'b0, 1'b1, 16'h0000);
    send_item(1'b0, 1'b1, SYNC_GAP_RST);
    send_item(1'b0, 1'b0, 16'd1000);
    send_item(1'b0, 1'b1, SYNC_GAP_RST + 16'd1);
    send_item(1'b0, 1'b1, 16'hFFFF);

    // three idle patterns, each over every register setting
    for (int m = 0; m < 3; m++) begin
      snd_idle_pct = (m == 0) ? 6 : (m == 1) ? 84 : 0;
      rcv_stall_pct = (m == 0) ? 84 : (m == 1) ? 6 : 0;
      for (int k = 0; k < NUM_SETTINGS; k++) begin
        settle();
        cur = plan_of(k);
        write_reg(REG_MIN_PULSE, cur.min_p);
        write_reg(REG_MAX_PULSE, cur.max_p);
        write_reg(REG_SYNC_GAP, cur.sync);
        write_reg(REG_BIT_BOUND, cur.bound);
        write_reg(REG_HOLD, cur.hold);
        n_settings++;
        run_phase();
      end
    end

    settle();
    $display("summary: %0d items over %0d register settings, %0d results checked",
             n_items, n_settings, n_results);
    $display("summary: %0d frames decoded, %0d codes reported, %0d hold timeouts, %0d mismatches",
             n_decoded, n_reported, n_timeouts, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
